/* design/assert_macros.svh */
// Assertion helpers for the design files; sfdt_back.sv uses them.
// Each macro expands to one labeled concurrent assertion that is
// disabled while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SFDT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SFDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `SFDT_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

/* design/sfdt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer package
// Request and result types, the command passed from parser to executor,
// byte and channel codes, and the channel to column decode.
// ----------------------------------------------------------------------------
package sfdt_pkg;

    localparam logic       FUNC_BYTE  = 1'b0;
    localparam logic       FUNC_TARE  = 1'b1;
    localparam logic       KIND_FRAME = 1'b0;
    localparam logic       KIND_TARE  = 1'b1;

    localparam logic [7:0] BYTE_SOF   = 8'h3F;
    localparam logic [7:0] BYTE_EOF   = 8'h21;

    localparam logic [7:0] CH_COL0    = 8'h08;
    localparam logic [7:0] CH_COL1    = 8'h09;
    localparam logic [7:0] CH_COL2    = 8'h0A;
    localparam logic [7:0] CH_COL3    = 8'h0B;
    localparam logic [7:0] CH_COL4    = 8'h0C;

    localparam logic [2:0] COL_0      = 3'd0;
    localparam logic [2:0] COL_1      = 3'd1;
    localparam logic [2:0] COL_2      = 3'd2;
    localparam logic [2:0] COL_3      = 3'd3;
    localparam logic [2:0] COL_4      = 3'd4;
    localparam logic [2:0] COL_NONE   = 3'd5;
    localparam logic [2:0] COL_TARE_LAST = COL_3;

    localparam int         CMD_DEPTH  = 2;
    localparam int         RES_DEPTH  = 2;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [7:0]        module_id;
        logic [7:0]        channel_code;
        logic signed [31:0] sample_value;
        logic [3:0]        row_index;
        logic [2:0]        column_index;
        logic              ring_wrapped;
        logic              last_result;
    } t_out_item;

    typedef struct packed {
        logic        is_tare;
        logic [7:0]  module_id;
        logic [7:0]  channel_code;
        logic [31:0] value;
    } t_cmd;

    function automatic logic [2:0] f_channel_col(input logic [7:0] ch);
        logic [2:0] col;
        case (ch)
            CH_COL0: col = COL_0;
            CH_COL1: col = COL_1;
            CH_COL2: col = COL_2;
            CH_COL3: col = COL_3;
            CH_COL4: col = COL_4;
            default: col = COL_NONE;
        endcase
        return col;
    endfunction

endpackage

/* design/sfdt_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-in first-out buffer used between the parser and the
// executor and in front of the result port.
// ----------------------------------------------------------------------------
module sfdt_fifo #(
    parameter type t_item = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* design/sfdt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser
// Takes one request per cycle while the command queue has room, tracks the
// frame position, and commands each tare request and each EOF-ended frame.
// ----------------------------------------------------------------------------
module sfdt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sfdt_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_cmd_push,
    output sfdt_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_full
);

    import sfdt_pkg::*;

    logic       r_in_frame, n_in_frame;
    logic [2:0] r_byte_count, n_byte_count;
    logic [7:0] r_module;
    logic [7:0] r_channel;
    logic [7:0] r_value_bytes [4];
    logic       accept;
    logic       is_byte;
    logic [2:0] byte_off;
    logic [1:0] value_idx;

    assign o_full    = i_cmd_full;
    assign accept    = i_push && !i_cmd_full;
    assign is_byte   = (i_item.func == FUNC_BYTE);
    assign byte_off  = r_byte_count - 3'd3;
    assign value_idx = byte_off[1:0];

    always_comb begin
        n_in_frame   = r_in_frame;
        n_byte_count = r_byte_count;
        o_cmd_push   = 1'b0;
        o_cmd.is_tare      = !is_byte;
        o_cmd.module_id    = r_module;
        o_cmd.channel_code = r_channel;
        o_cmd.value        = {r_value_bytes[0], r_value_bytes[1],
                              r_value_bytes[2], r_value_bytes[3]};
        if (accept) begin
            if (!is_byte) begin
                o_cmd_push = 1'b1;
            end else if (!r_in_frame) begin
                if (i_item.rx_byte == BYTE_SOF) begin
                    n_in_frame   = 1'b1;
                    n_byte_count = 3'd1;
                end else begin
                    n_byte_count = 3'd0;
                end
            end else if (r_byte_count == 3'd7) begin
                n_in_frame   = 1'b0;
                n_byte_count = 3'd0;
                o_cmd_push   = (i_item.rx_byte == BYTE_EOF);
            end else begin
                n_byte_count = r_byte_count + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_byte_count <= 3'd0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_byte_count <= n_byte_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_byte && r_in_frame) begin
            case (r_byte_count)
                3'd1:    r_module  <= i_item.rx_byte;
                3'd2:    r_channel <= i_item.rx_byte;
                3'd3, 3'd4, 3'd5, 3'd6: r_value_bytes[value_idx] <= i_item.rx_byte;
                default: ;
            endcase
        end
    end

endmodule

/* design/sfdt_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Frame executor
// Stores frames in the history ring, advances the ring row and works out
// the tare averages with a read-accumulate pass and a reciprocal
// multiplication that takes one chunk of the column sum per cycle.
// ----------------------------------------------------------------------------
module sfdt_back #(
    parameter int ROWS           = 10,
    parameter int FRAMES_PER_ROW = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfdt_pkg::t_cmd      i_cmd,
    input  logic                i_cmd_empty,
    output logic                o_cmd_pop,
    output logic                o_res_push,
    output sfdt_pkg::t_out_item o_res,
    input  logic                i_res_full
);

    import sfdt_pkg::*;

    localparam int ROW_W   = $clog2(ROWS);
    localparam int ADDR_W  = ROW_W + 3;
    localparam int MEM_D   = ROWS * 8;
    localparam int SUM_W   = 32 + ROW_W;
    localparam int SHIFT   = SUM_W + ROW_W;
    localparam int RCP_W   = SUM_W + 1;
    localparam int CHUNK_W = 12;
    localparam int N_CHUNK = (SUM_W + CHUNK_W - 1) / CHUNK_W;
    localparam int ACC_W   = CHUNK_W + RCP_W;
    localparam int Q_LSB   = SHIFT - CHUNK_W * (N_CHUNK - 1);
    localparam int CNT_W   = (N_CHUNK > 1) ? $clog2(N_CHUNK) : 1;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << SHIFT) + 64'(ROWS) - 64'd1) / 64'(ROWS));

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_ABS  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_fir, n_fir;
    logic [3:0]       r_row, n_row;
    logic [2:0]       r_col, n_col;
    logic [ROW_W-1:0] r_rd_row, n_rd_row;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [SUM_W-1:0] r_mag, n_mag;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_neg, n_neg;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [31:0]      r_mem [MEM_D];
    logic [MEM_D-1:0] r_valid;
    logic [31:0]      r_rdata;
    logic             r_rd_valid;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic [2:0]  frame_col;
    logic [3:0]  fir_inc;
    logic [4:0]  row_inc;
    logic        advance;
    logic        wrap;
    logic        do_frame;
    logic [31:0] rd_val;
    logic [SUM_W-1:0] rd_ext;
    logic [ACC_W-1:0] mul_part;
    logic [31:0] quo;
    logic [31:0] tare_val;

    assign frame_col = f_channel_col(i_cmd.channel_code);
    assign fir_inc   = {1'b0, r_fir} + 4'd1;
    assign row_inc   = {1'b0, r_row} + 5'd1;
    assign advance   = (fir_inc >= 4'(FRAMES_PER_ROW));
    assign wrap      = advance && (row_inc >= 5'(ROWS));
    assign do_frame  = (r_state == ST_IDLE) && !i_cmd_empty && !i_cmd.is_tare && !i_res_full;

    assign wr_en   = do_frame && (frame_col != COL_NONE);
    assign wr_addr = {r_row[ROW_W-1:0], frame_col};
    assign rd_en   = (r_state == ST_RD);
    assign rd_addr = {r_rd_row, r_col};

    assign rd_val   = r_rd_valid ? r_rdata : 32'd0;
    assign rd_ext   = {{(SUM_W - 32){rd_val[31]}}, rd_val};
    assign mul_part = ACC_W'(r_mag[CHUNK_W-1:0]) * ACC_W'(RECIP);
    assign quo      = r_acc[Q_LSB +: 32];
    assign tare_val = r_neg ? (32'd0 - quo) : quo;

    always_comb begin
        n_state  = r_state;
        n_fir    = r_fir;
        n_row    = r_row;
        n_col    = r_col;
        n_rd_row = r_rd_row;
        n_sum    = r_sum;
        n_mag    = r_mag;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;

        o_res.kind         = KIND_FRAME;
        o_res.module_id    = i_cmd.module_id;
        o_res.channel_code = i_cmd.channel_code;
        o_res.sample_value = signed'(i_cmd.value);
        o_res.row_index    = r_row;
        o_res.column_index = frame_col;
        o_res.ring_wrapped = wrap;
        o_res.last_result  = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.is_tare) begin
                        o_cmd_pop = 1'b1;
                        n_col     = COL_0;
                        n_rd_row  = '0;
                        n_sum     = '0;
                        n_state   = ST_RD;
                    end else if (!i_res_full) begin
                        o_cmd_pop  = 1'b1;
                        o_res_push = 1'b1;
                        if (advance) begin
                            n_fir = 3'd0;
                            n_row = wrap ? 4'd0 : row_inc[3:0];
                        end else begin
                            n_fir = fir_inc[2:0];
                        end
                    end
                end
            end
            ST_RD: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_sum = r_sum + rd_ext;
                if (r_rd_row == ROW_W'(ROWS - 1)) begin
                    n_state = ST_ABS;
                end else begin
                    n_rd_row = r_rd_row + ROW_W'(1);
                    n_state  = ST_RD;
                end
            end
            ST_ABS: begin
                n_neg   = r_sum[SUM_W-1];
                n_mag   = r_sum[SUM_W-1] ? ('0 - r_sum) : r_sum;
                n_acc   = '0;
                n_cnt   = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_acc = (r_acc >> CHUNK_W) + mul_part;
                n_mag = r_mag >> CHUNK_W;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(N_CHUNK - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_res.kind         = KIND_TARE;
                o_res.module_id    = 8'd0;
                o_res.channel_code = 8'd0;
                o_res.sample_value = signed'(tare_val);
                o_res.row_index    = 4'd0;
                o_res.column_index = r_col;
                o_res.ring_wrapped = 1'b0;
                o_res.last_result  = (r_col == COL_TARE_LAST);
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_col == COL_TARE_LAST) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_col    = r_col + 3'd1;
                        n_rd_row = '0;
                        n_sum    = '0;
                        n_state  = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fir    <= 3'd0;
            r_row    <= 4'd0;
            r_col    <= COL_0;
            r_rd_row <= '0;
            r_neg    <= 1'b0;
            r_cnt    <= '0;
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_fir    <= n_fir;
            r_row    <= n_row;
            r_col    <= n_col;
            r_rd_row <= n_rd_row;
            r_neg    <= n_neg;
            r_cnt    <= n_cnt;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_mag <= n_mag;
        r_acc <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.value;
        end
        if (rd_en) begin
            r_rdata    <= r_mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    `SFDT_ASSERT(a_tare_push_in_out, i_clk, i_rst_n, (o_res_push && (o_res.kind == KIND_TARE)) |-> (r_state == ST_OUT), "tare result pushed outside the output step")
    `SFDT_ASSERT_NEXT(a_tare_done_idle, i_clk, i_rst_n, (r_state == ST_OUT) && o_res_push && (r_col == COL_TARE_LAST), r_state == ST_IDLE, "executor did not return to idle after the last tare column")
    `SFDT_ASSERT(a_mag_used, i_clk, i_rst_n, (r_state == ST_OUT) |-> (r_mag == '0), "tare magnitude not fully consumed")
    `SFDT_ASSERT(a_row_range, i_clk, i_rst_n, ({1'b0, r_row} < 5'(ROWS)) && ({1'b0, r_fir} < 4'(FRAMES_PER_ROW)), "ring row or frame count out of range")

endmodule

/* design/sensor_frame_deframer_tare.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer with history ring and tare
// Parses serial bytes into framed sensor samples, keeps a history ring of
// the stored channels and reports per-column tare averages on request.
// ----------------------------------------------------------------------------
// The parser keeps taking received bytes while the executor is busy, as
// long as the two-entry command queue has room. A completed frame is
// reported by the executor and stored when its channel maps to a column. A
// tare request occupies the executor while it picks up the request, then for
// each of columns 0 to 3 reads back the history entries one by one through
// the single read port, each read followed by an accumulate step, takes the
// magnitude of the sum, divides it by ROWS by chunked reciprocal
// multiplication, and sends the average out when the result queue has room.
// The history ring is empty right after reset with no clearing pass, since
// per-entry valid bits are cleared with reset.
module sensor_frame_deframer_tare #(
    parameter int ROWS           = 10,
    parameter int FRAMES_PER_ROW = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  sfdt_pkg::t_in_item  i_item,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output sfdt_pkg::t_out_item o_result
);

    import sfdt_pkg::*;

    logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
    t_cmd      cmd_in, cmd_out;
    logic      res_push, res_full;
    t_out_item res_in;

    sfdt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    sfdt_fifo #(
        .t_item (t_cmd),
        .DEPTH  (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_out)
    );

    sfdt_back #(
        .ROWS           (ROWS),
        .FRAMES_PER_ROW (FRAMES_PER_ROW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    sfdt_fifo #(
        .t_item (t_out_item),
        .DEPTH  (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

endmodule
